// File: src/mes_pkg.sv
// ----------------------------------------------------------------------------
// mes_pkg
// Shared constants, types and helper functions of the edit script unit.
// ----------------------------------------------------------------------------
package mes_pkg;

    localparam int MAX_LEN      = 32;
    localparam int TOKEN_BITS   = 32;
    localparam int IDX_W        = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W        = $clog2(MAX_LEN + 1);
    localparam int SNAP_DEPTH   = 2 * MAX_LEN + 1;
    localparam int LAYER_W      = $clog2(2 * MAX_LEN + 1);
    localparam int SNAP_AW      = 2 * LAYER_W;
    localparam int SNAP_WORDS   = 1 << SNAP_AW;
    localparam int FR_W         = $clog2(3 * MAX_LEN + 1);
    localparam int CRD_W        = $clog2(5 * MAX_LEN + 1) + 1;
    localparam int SCRIPT_DEPTH = 2 * MAX_LEN;
    localparam int SCR_AW       = $clog2(SCRIPT_DEPTH);
    localparam int LEN_W        = $clog2(SCRIPT_DEPTH + 1);

    // command opcodes
    localparam logic [1:0] OPC_OLD = 2'd0;
    localparam logic [1:0] OPC_NEW = 2'd1;
    localparam logic [1:0] OPC_RUN = 2'd2;

    // script op codes
    localparam logic [1:0] EOP_KEEP  = 2'd0;
    localparam logic [1:0] EOP_DEL   = 2'd1;
    localparam logic [1:0] EOP_INS   = 2'd2;
    localparam logic [1:0] EOP_EMPTY = 2'd3;

    typedef logic signed [CRD_W-1:0] crd_t;
    typedef logic signed [CRD_W:0]   crdx_t;
    typedef logic [FR_W-1:0]         fr_t;
    typedef logic [LAYER_W-1:0]      layer_t;

    localparam crd_t  CRD_ONE  = 1;
    localparam crd_t  CRD_TWO  = 2;
    localparam crdx_t CRDX_ONE = 1;
    localparam crdx_t CRDX_TWO = 2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_RUN,
        DP_RD_A,
        DP_RD_B,
        DP_CALC,
        DP_SNAKE,
        DP_WRITE,
        DP_BT_INIT,
        DP_BT_RD_A,
        DP_BT_RD_B,
        DP_BT_CALC,
        DP_BT_STEP,
        DP_OUT_RD,
        DP_OUT,
        DP_EMPTY
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic empty_pair;
        logic snake_more;
        logic reached_end;
        logic layer_last;
        logic search_done;
        logic keep_more;
        logic bt_done;
        logic out_none;
        logic out_last;
    } dp_stat_t;

    typedef struct packed {
        logic               hit;
        logic [SNAP_AW-1:0] addr;
    } snap_rd_t;

    // Down move (insert) rule shared by search and backtrack.
    function automatic logic take_down(fr_t a, fr_t b, crd_t k, layer_t d);
        crd_t dk;
        dk = crd_t'(d);
        return (k == -dk) || ((k != dk) && (a < b));
    endfunction

    // Frontier entry i as seen before layer dd: it was last written by the
    // newest earlier layer of the same parity, or is still zero.
    function automatic snap_rd_t snap_lookup(layer_t dd, crd_t i);
        crdx_t    di;
        crdx_t    ii;
        crdx_t    lyr;
        crdx_t    jj;
        snap_rd_t r;
        di    = crdx_t'(dd);
        ii    = crdx_t'(i);
        lyr   = (ii[0] != di[0]) ? (di - CRDX_ONE) : (di - CRDX_TWO);
        jj    = (ii + lyr) >>> 1;
        r.hit = !lyr[CRD_W] && (ii <= lyr) && (ii >= -lyr);
        r.addr = {lyr[LAYER_W-1:0], jj[LAYER_W-1:0]};
        return r;
    endfunction

endpackage

// File: src/mes_ram.sv
// ----------------------------------------------------------------------------
// mes_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mes_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/mes_dp.sv
// ----------------------------------------------------------------------------
// mes_dp
// Datapath: token stores, search and backtrack registers, snapshot and
// script RAMs, result registers.
// ----------------------------------------------------------------------------
module mes_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        opcode,
    input  logic [31:0]       token,
    input  mes_pkg::dp_cmd_t  cmd,
    output mes_pkg::dp_stat_t stat,
    output logic [1:0]        edit_op,
    output logic              last_op,
    output logic              overflow
);
    import mes_pkg::*;

    logic [TOKEN_BITS-1:0] old_mem [MAX_LEN];
    logic [TOKEN_BITS-1:0] new_mem [MAX_LEN];

    logic [CNT_W-1:0]  old_cnt_reg, old_cnt_next;
    logic [CNT_W-1:0]  new_cnt_reg, new_cnt_next;
    logic              dropped_reg, dropped_next;

    logic [CNT_W-1:0]  n_reg, m_reg;
    logic              ovf_reg;
    layer_t            d_reg;
    crd_t              k_reg, x_reg, y_reg;
    crd_t              cx_reg, cy_reg, px_reg, py_reg;
    fr_t               a_reg;
    logic              hit_reg;
    logic              down_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [SCR_AW-1:0] oidx_reg;
    logic [1:0]        edit_op_reg;
    logic              last_op_reg;
    logic              overflow_reg;

    logic              old_full, new_full, len_full;
    crd_t              n_s, m_s, d_s, kk, idx_sel;
    crd_t              a_c, b_c, x_calc, jw;
    crd_t              pk, pxo, px_calc, py_calc;
    fr_t               snap_rdata, rd_val;
    snap_rd_t          lk;
    logic              down_f, down_b;
    logic [LAYER_W:0]  d1, total;
    logic              snap_we;
    logic              scr_we;
    logic [1:0]        scr_wdata, scr_rdata;
    logic [SCR_AW-1:0] scr_raddr;

    assign old_full = (old_cnt_reg == CNT_W'(MAX_LEN));
    assign new_full = (new_cnt_reg == CNT_W'(MAX_LEN));
    assign len_full = (len_reg == LEN_W'(SCRIPT_DEPTH));

    assign n_s = crd_t'(n_reg);
    assign m_s = crd_t'(m_reg);
    assign d_s = crd_t'(d_reg);
    assign kk  = cx_reg - cy_reg;

    always_comb
    begin
        case (cmd.op)
            DP_RD_A:    idx_sel = k_reg - CRD_ONE;
            DP_RD_B:    idx_sel = k_reg + CRD_ONE;
            DP_BT_RD_A: idx_sel = kk - CRD_ONE;
            DP_BT_RD_B: idx_sel = kk + CRD_ONE;
            default:    idx_sel = k_reg;
        endcase
    end

    assign lk     = snap_lookup(d_reg, idx_sel);
    assign rd_val = hit_reg ? snap_rdata : '0;
    assign a_c    = crd_t'(a_reg);
    assign b_c    = crd_t'(rd_val);

    // forward step on diagonal k
    assign down_f = take_down(a_reg, rd_val, k_reg, d_reg);
    assign x_calc = down_f ? b_c : (a_c + CRD_ONE);
    assign jw     = (k_reg + d_s) >>> 1;

    // backtrack step on diagonal cx - cy
    assign down_b  = take_down(a_reg, rd_val, kk, d_reg);
    assign pk      = down_b ? (kk + CRD_ONE) : (kk - CRD_ONE);
    assign pxo     = down_b ? b_c : a_c;
    assign px_calc = down_b ? pxo : (pxo + CRD_ONE);
    assign py_calc = pxo - pk;

    assign d1    = {1'b0, d_reg} + (LAYER_W+1)'(1);
    assign total = (LAYER_W+1)'(n_reg) + (LAYER_W+1)'(m_reg);

    always_comb
    begin
        stat.empty_pair  = (old_cnt_reg == '0) && (new_cnt_reg == '0);
        stat.snake_more  = (x_reg >= 0) && (y_reg >= 0) && (x_reg < n_s) && (y_reg < m_s)
                           && (old_mem[x_reg[IDX_W-1:0]] == new_mem[y_reg[IDX_W-1:0]]);
        stat.reached_end = (x_reg >= n_s) && (y_reg >= m_s);
        stat.layer_last  = (k_reg == d_s);
        stat.search_done = (d1 > total) || (d1 >= (LAYER_W+1)'(SNAP_DEPTH));
        stat.keep_more   = (cx_reg > px_reg) && (cy_reg > py_reg);
        stat.bt_done     = (d_reg == '0);
        stat.out_none    = (len_reg == '0);
        stat.out_last    = (oidx_reg == '0);
    end

    assign snap_we   = (cmd.op == DP_WRITE);
    assign scr_we    = (cmd.op == DP_BT_STEP) && !len_full && (stat.keep_more || !stat.bt_done);
    assign scr_wdata = stat.keep_more ? EOP_KEEP : (down_reg ? EOP_INS : EOP_DEL);
    assign scr_raddr = (cmd.op == DP_OUT_RD) ? SCR_AW'(len_reg - LEN_W'(1))
                                             : (oidx_reg - SCR_AW'(1));

    mes_ram #(
        .WIDTH (FR_W),
        .DEPTH (SNAP_WORDS)
    ) u_snap_ram (
        .clk   (clk),
        .we    (snap_we),
        .waddr ({d_reg, jw[LAYER_W-1:0]}),
        .wdata (x_reg[FR_W-1:0]),
        .raddr (lk.addr),
        .rdata (snap_rdata)
    );

    mes_ram #(
        .WIDTH (2),
        .DEPTH (SCRIPT_DEPTH)
    ) u_script_ram (
        .clk   (clk),
        .we    (scr_we),
        .waddr (len_reg[SCR_AW-1:0]),
        .wdata (scr_wdata),
        .raddr (scr_raddr),
        .rdata (scr_rdata)
    );

    // load counters and drop flag
    always_comb
    begin
        old_cnt_next = old_cnt_reg;
        new_cnt_next = new_cnt_reg;
        dropped_next = dropped_reg;
        case (cmd.op)
            DP_LOAD:
            begin
                if (opcode == OPC_OLD)
                begin
                    if (old_full)
                        dropped_next = 1'b1;
                    else
                        old_cnt_next = old_cnt_reg + CNT_W'(1);
                end
                else if (opcode == OPC_NEW)
                begin
                    if (new_full)
                        dropped_next = 1'b1;
                    else
                        new_cnt_next = new_cnt_reg + CNT_W'(1);
                end
            end
            DP_RUN:
            begin
                old_cnt_next = '0;
                new_cnt_next = '0;
                dropped_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_cnt_reg <= '0;
            new_cnt_reg <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            old_cnt_reg <= old_cnt_next;
            new_cnt_reg <= new_cnt_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                if ((opcode == OPC_OLD) && !old_full)
                    old_mem[old_cnt_reg[IDX_W-1:0]] <= token[TOKEN_BITS-1:0];
                if ((opcode == OPC_NEW) && !new_full)
                    new_mem[new_cnt_reg[IDX_W-1:0]] <= token[TOKEN_BITS-1:0];
            end
            DP_RUN:
            begin
                n_reg   <= old_cnt_reg;
                m_reg   <= new_cnt_reg;
                ovf_reg <= dropped_reg;
                d_reg   <= '0;
                k_reg   <= '0;
            end
            DP_RD_A, DP_BT_RD_A:
            begin
                hit_reg <= lk.hit;
            end
            DP_RD_B, DP_BT_RD_B:
            begin
                hit_reg <= lk.hit;
                a_reg   <= rd_val;
            end
            DP_CALC:
            begin
                x_reg <= x_calc;
                y_reg <= x_calc - k_reg;
            end
            DP_SNAKE:
            begin
                if (stat.snake_more)
                begin
                    x_reg <= x_reg + CRD_ONE;
                    y_reg <= y_reg + CRD_ONE;
                end
            end
            DP_WRITE:
            begin
                if (!stat.reached_end)
                begin
                    if (stat.layer_last)
                    begin
                        d_reg <= d_reg + LAYER_W'(1);
                        k_reg <= -d_s - CRD_ONE;
                    end
                    else
                    begin
                        k_reg <= k_reg + CRD_TWO;
                    end
                end
            end
            DP_BT_INIT:
            begin
                cx_reg  <= n_s;
                cy_reg  <= m_s;
                len_reg <= '0;
            end
            DP_BT_CALC:
            begin
                down_reg <= down_b;
                px_reg   <= px_calc;
                py_reg   <= py_calc;
            end
            DP_BT_STEP:
            begin
                if (stat.keep_more)
                begin
                    if (!len_full)
                        len_reg <= len_reg + LEN_W'(1);
                    cx_reg <= cx_reg - CRD_ONE;
                    cy_reg <= cy_reg - CRD_ONE;
                end
                else
                begin
                    if (!stat.bt_done && !len_full)
                        len_reg <= len_reg + LEN_W'(1);
                    cx_reg <= px_reg;
                    cy_reg <= py_reg;
                    if (!stat.bt_done)
                        d_reg <= d_reg - LAYER_W'(1);
                end
            end
            DP_OUT_RD:
            begin
                oidx_reg <= SCR_AW'(len_reg - LEN_W'(1));
            end
            DP_OUT:
            begin
                edit_op_reg  <= scr_rdata;
                last_op_reg  <= stat.out_last;
                overflow_reg <= ovf_reg;
                oidx_reg     <= oidx_reg - SCR_AW'(1);
            end
            DP_EMPTY:
            begin
                edit_op_reg  <= EOP_EMPTY;
                last_op_reg  <= 1'b1;
                overflow_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign edit_op  = edit_op_reg;
    assign last_op  = last_op_reg;
    assign overflow = overflow_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (old_cnt_reg <= CNT_W'(MAX_LEN)) && (new_cnt_reg <= CNT_W'(MAX_LEN)))
        else $error("token count beyond capacity");

    a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_RUN) |=> (old_cnt_reg == '0) && (new_cnt_reg == '0) && !dropped_reg)
        else $error("run did not clear load state");
`endif

endmodule

// File: src/mes_ctrl.sv
// ----------------------------------------------------------------------------
// mes_ctrl
// Sequencer: load, forward search, backtrack and script readout.
// ----------------------------------------------------------------------------
module mes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        opcode,
    input  mes_pkg::dp_stat_t stat,
    output mes_pkg::dp_cmd_t  cmd,
    output logic              busy,
    output logic              strobe
);
    import mes_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_RD_A,
        ST_RD_B,
        ST_CALC,
        ST_SNAKE,
        ST_WRITE,
        ST_BT_INIT,
        ST_BT_RD_A,
        ST_BT_RD_B,
        ST_BT_CALC,
        ST_BT_STEP,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   strobe_reg;

    always_comb
    begin
        cmd.op = DP_NOP;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode inside {OPC_OLD, OPC_NEW})
                        cmd.op = DP_LOAD;
                    else if (opcode == OPC_RUN)
                        cmd.op = DP_RUN;
                end
            end
            ST_EMPTY:   cmd.op = DP_EMPTY;
            ST_RD_A:    cmd.op = DP_RD_A;
            ST_RD_B:    cmd.op = DP_RD_B;
            ST_CALC:    cmd.op = DP_CALC;
            ST_SNAKE:   cmd.op = DP_SNAKE;
            ST_WRITE:   cmd.op = DP_WRITE;
            ST_BT_INIT: cmd.op = DP_BT_INIT;
            ST_BT_RD_A: cmd.op = DP_BT_RD_A;
            ST_BT_RD_B: cmd.op = DP_BT_RD_B;
            ST_BT_CALC: cmd.op = DP_BT_CALC;
            ST_BT_STEP: cmd.op = DP_BT_STEP;
            ST_OUT_RD:  cmd.op = DP_OUT_RD;
            ST_OUT:     cmd.op = DP_OUT;
            default:    cmd.op = DP_NOP;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (opcode == OPC_RUN))
                    state_next = stat.empty_pair ? ST_EMPTY : ST_RD_A;
            end
            ST_EMPTY:   state_next = ST_IDLE;
            ST_RD_A:    state_next = ST_RD_B;
            ST_RD_B:    state_next = ST_CALC;
            ST_CALC:    state_next = ST_SNAKE;
            ST_SNAKE:
            begin
                if (!stat.snake_more)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (stat.reached_end)
                    state_next = ST_BT_INIT;
                else if (stat.layer_last && stat.search_done)
                    state_next = ST_IDLE;
                else
                    state_next = ST_RD_A;
            end
            ST_BT_INIT: state_next = ST_BT_RD_A;
            ST_BT_RD_A: state_next = ST_BT_RD_B;
            ST_BT_RD_B: state_next = ST_BT_CALC;
            ST_BT_CALC: state_next = ST_BT_STEP;
            ST_BT_STEP:
            begin
                if (!stat.keep_more)
                    state_next = stat.bt_done ? ST_OUT_RD : ST_BT_RD_A;
            end
            ST_OUT_RD:  state_next = stat.out_none ? ST_IDLE : ST_OUT;
            ST_OUT:
            begin
                if (stat.out_last)
                    state_next = ST_IDLE;
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == ST_OUT) || (state_reg == ST_EMPTY);
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;

`ifndef SYNTHESIS
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past((state_reg == ST_OUT) || (state_reg == ST_EMPTY)))
        else $error("strobe without readout state");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_IDLE) && start && (opcode == OPC_RUN)) |=> busy)
        else $error("run transaction did not raise busy");
`endif

endmodule

// File: src/myers_edit_script_unit.sv
// ----------------------------------------------------------------------------
// myers_edit_script_unit
// Myers O(ND) greedy diff over two token lists, emitting the edit script.
// ----------------------------------------------------------------------------
// Load transaction (append old/new): busy stays low, no result.
// Run: per diagonal two frontier reads, a compute, a snake walk over matched
//   tokens and a frontier write in the search, then a setup step and per
//   edit layer two reads, a compute and a step walk over kept tokens in
//   backtrack, a read, then one op per cycle; an empty pair gives its marker.
// The single snapshot RAM port (two reads per diagonal) sets the search pace.
// Results cannot be stalled. Async reset clears counts, flag and sequencer;
// token and snapshot storage stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
module myers_edit_script_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  opcode,
    input  logic [31:0] token,
    output logic        busy,
    output logic        strobe,
    output logic [1:0]  edit_op,
    output logic        last_op,
    output logic        overflow
);
    import mes_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The sequencer walks diagonals k = -d..d step 2 per layer d, each with
    // two frontier reads, a compute and a snake walk, then a frontier write.
    // On reaching the end it backtracks layer by layer from (n, m), storing
    // ops in reverse, and plays the script out forward, one transaction per
    // cycle with last_op on the final op.
    mes_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (strobe)
    );

    // Datapath holds the token stores, the per-layer frontier snapshots
    // (addressed by layer and diagonal slot) and the reversed script buffer.
    mes_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .opcode   (opcode),
        .token    (token),
        .cmd      (cmd),
        .stat     (stat),
        .edit_op  (edit_op),
        .last_op  (last_op),
        .overflow (overflow)
    );

`ifndef SYNTHESIS
    // the last op of a script is never directly followed by another result
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_op) |=> !strobe)
        else $error("result right after last op");
`endif

endmodule
